>>> design/mpeg4_inverse_acdc_prediction_top_defines.svh
// Assertion macros shared by the inverse AC/DC prediction RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef MPEG4_INVERSE_ACDC_PREDICTION_TOP_DEFINES_SVH
`define MPEG4_INVERSE_ACDC_PREDICTION_TOP_DEFINES_SVH

// implication in the same cycle
`define M4ACDC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("m4acdc assertion failed");

// implication in the following cycle
`define M4ACDC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("m4acdc assertion failed");

`endif

>>> design/m4acdc_pkg.sv
// Types, constants and the DC scaler rule for inverse AC/DC prediction.
// No dependencies; used by the divider cell and the top level.
`default_nettype none
package m4acdc_pkg;

	localparam int COEF_BITS_DEF = 12;
	localparam int PRED_BITS     = 16;
	localparam int QP_BITS       = 5;
	localparam int DEN_BITS      = 6;
	localparam int NUM_BITS      = 20;
	localparam int PROD_BITS     = PRED_BITS + 1 + QP_BITS;
	localparam int SUM_BITS      = NUM_BITS + 2;
	localparam int CFG_DATA_BITS = 5;

	localparam logic CFG_QUANT   = 1'b0;
	localparam logic CFG_AC_PRED = 1'b1;

	typedef enum logic [1:0] {
		MODE_PASS,
		MODE_DC,
		MODE_AC
	} mode_t;

	typedef struct packed {
		mode_t                 mode;
		logic                  neg;
		logic [DEN_BITS-1:0]   den;
		logic [DEN_BITS-1:0]   scaler;
		logic [NUM_BITS-1:0]   num;
		logic [NUM_BITS-1:0]   quot;
		logic [DEN_BITS-1:0]   rem;
	} div_t;

	function automatic logic [DEN_BITS-1:0] dc_scale_f(logic [QP_BITS-1:0] q, logic chroma);
		logic [DEN_BITS-1:0] qe;
		logic [DEN_BITS-1:0] r;
		qe = {1'b0, q};
		if (q < 5'd5) begin
			r = 6'd8;
		end else if (!chroma) begin
			if (q < 5'd9)
				r = {q, 1'b0};
			else if (q < 5'd25)
				r = qe + 6'd8;
			else
				r = {q, 1'b0} - 6'd16;
		end else begin
			if (q < 5'd25)
				r = (qe + 6'd13) >> 1;
			else
				r = qe - 6'd6;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

>>> design/m4acdc_div_cell.sv
// One restoring-division cell: resolves one quotient bit per transaction.
// Depends on m4acdc_pkg (div_t).
`default_nettype none
module m4acdc_div_cell #(
	parameter int COEF_BITS = m4acdc_pkg::COEF_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  en,
	input  wire logic                  in_valid,
	input  wire logic [COEF_BITS-1:0]  in_coef,
	input  wire m4acdc_pkg::div_t      in_stage,
	output logic                       out_valid,
	output logic [COEF_BITS-1:0]       out_coef,
	output m4acdc_pkg::div_t           out_stage
);

	logic                             valid_q;
	logic [COEF_BITS-1:0]             coef_q;
	m4acdc_pkg::div_t                 stage_q;
	m4acdc_pkg::div_t                 stage_d;
	logic [m4acdc_pkg::DEN_BITS:0]    trial;
	logic [m4acdc_pkg::DEN_BITS:0]    den_ext;
	logic                             ge;

	always_comb begin
		trial   = {in_stage.rem, in_stage.num[m4acdc_pkg::NUM_BITS-1]};
		den_ext = {1'b0, in_stage.den};
		ge      = (trial >= den_ext);
		stage_d = in_stage;
		stage_d.rem  = ge ? m4acdc_pkg::DEN_BITS'(trial - den_ext)
		                  : m4acdc_pkg::DEN_BITS'(trial);
		stage_d.num  = {in_stage.num[m4acdc_pkg::NUM_BITS-2:0], 1'b0};
		stage_d.quot = {in_stage.quot[m4acdc_pkg::NUM_BITS-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			coef_q  <= in_coef;
			stage_q <= stage_d;
		end
	end

	assign out_valid = valid_q;
	assign out_coef  = coef_q;
	assign out_stage = stage_q;

endmodule
`default_nettype wire

>>> design/mpeg4_inverse_acdc_prediction_top.sv
// Inverse AC/DC prediction for MPEG-4 Part 2 intra coefficients.
// Depends on m4acdc_pkg, m4acdc_div_cell and the assertion macro header.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one coefficient per transaction
//   with its raster index, predictor, block type, direction and qp_pred.
//   Output channel (out_valid/out_ready) returns qf_value and dc_scale,
//   one transaction per input, in order.
//   quant and ac_pred_enable are written through cfg_we/cfg_index/cfg_data;
//   the user must write them only while the block is idle; the block itself does not enforce this.
//   Pipeline: one front stage (abs, multiply, rounding offset), a chain
//   of 20 divider cells that each settle one quotient bit, and an output
//   register that adds and saturates.
//   Throughput is one transaction per cycle while the receiver does not stall;
//   the divider chain is fully pipelined, so a new coefficient can enter every cycle.
//   Reset empties the pipeline and sets quant to 1, ac_pred_enable to 0.
//   When the receiver stalls the whole chain holds and in_ready drops;
//   it resumes without loss once out_ready returns.
`default_nettype none
`include "mpeg4_inverse_acdc_prediction_top_defines.svh"
module mpeg4_inverse_acdc_prediction_top #(
	parameter int COEF_BITS = m4acdc_pkg::COEF_BITS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic                                 cfg_index,
	input  wire logic [m4acdc_pkg::CFG_DATA_BITS-1:0] cfg_data,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic [5:0]                           coef_index,
	input  wire logic signed [COEF_BITS-1:0]          coef_value,
	input  wire logic signed [m4acdc_pkg::PRED_BITS-1:0] pred_value,
	input  wire logic                                 block_is_chroma,
	input  wire logic                                 direction,
	input  wire logic [m4acdc_pkg::QP_BITS-1:0]       qp_pred,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic signed [COEF_BITS-1:0]               qf_value,
	output logic [m4acdc_pkg::DEN_BITS-1:0]           dc_scale
);

	localparam int NB = m4acdc_pkg::NUM_BITS;
	localparam int SW = m4acdc_pkg::SUM_BITS;
	localparam logic signed [SW-1:0] SAT_HI = SW'((1 << (COEF_BITS - 1)) - 1);
	localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

	logic [m4acdc_pkg::QP_BITS-1:0]  quant_q;
	logic                            ac_pred_enable_q;
	logic                            en;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quant_q          <= m4acdc_pkg::QP_BITS'(1);
			ac_pred_enable_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				m4acdc_pkg::CFG_QUANT:   quant_q <= cfg_data;
				m4acdc_pkg::CFG_AC_PRED: ac_pred_enable_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// front stage
	logic [m4acdc_pkg::QP_BITS-1:0]     q_eff;
	logic [m4acdc_pkg::DEN_BITS-1:0]    scaler;
	logic [m4acdc_pkg::PRED_BITS:0]     pred_abs;
	logic [m4acdc_pkg::PROD_BITS-1:0]   prod;
	logic                               in_row;
	logic                               in_col;
	m4acdc_pkg::div_t                   front;

	always_comb begin
		q_eff    = (quant_q == '0) ? m4acdc_pkg::QP_BITS'(1) : quant_q;
		scaler   = m4acdc_pkg::dc_scale_f(q_eff, block_is_chroma);
		pred_abs = pred_value[m4acdc_pkg::PRED_BITS-1]
		           ? ((m4acdc_pkg::PRED_BITS+1)'(0)
		              - {pred_value[m4acdc_pkg::PRED_BITS-1], pred_value})
		           : {1'b0, pred_value};
		prod     = m4acdc_pkg::PROD_BITS'(pred_abs) * m4acdc_pkg::PROD_BITS'(qp_pred);
		in_row   = !direction && (coef_index[5:3] == 3'd0);
		in_col   = direction && (coef_index[2:0] == 3'd0);

		front.neg    = pred_value[m4acdc_pkg::PRED_BITS-1];
		front.scaler = scaler;
		front.quot   = '0;
		front.rem    = '0;
		if (coef_index == 6'd0) begin
			front.mode = m4acdc_pkg::MODE_DC;
			front.den  = scaler;
			front.num  = NB'(pred_abs) + NB'(scaler[m4acdc_pkg::DEN_BITS-1:1]);
		end else begin
			front.mode = (ac_pred_enable_q && (in_row || in_col) && (pred_value != '0))
			             ? m4acdc_pkg::MODE_AC : m4acdc_pkg::MODE_PASS;
			front.den  = {1'b0, q_eff};
			front.num  = NB'(prod + m4acdc_pkg::PROD_BITS'(q_eff[m4acdc_pkg::QP_BITS-1:1]));
		end
	end

	logic                  v_c    [0:NB];
	logic [COEF_BITS-1:0]  coef_c [0:NB];
	m4acdc_pkg::div_t      st_c   [0:NB];

	logic                  valid_s1;
	logic [COEF_BITS-1:0]  coef_s1;
	m4acdc_pkg::div_t      front_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			coef_s1  <= coef_value;
			front_s1 <= front;
		end
	end

	assign v_c[0]    = valid_s1;
	assign coef_c[0] = coef_s1;
	assign st_c[0]   = front_s1;

	// divider chain, one quotient bit per cell
	for (genvar i = 0; i < NB; i++) begin : g_cell
		m4acdc_div_cell #(
			.COEF_BITS (COEF_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (v_c[i]),
			.in_coef   (coef_c[i]),
			.in_stage  (st_c[i]),
			.out_valid (v_c[i+1]),
			.out_coef  (coef_c[i+1]),
			.out_stage (st_c[i+1])
		);
	end

	// add and saturate (DC/AC modes) or pass the coefficient, then register the result
	logic signed [SW-1:0]         coef_ext;
	logic signed [SW-1:0]         term;
	logic signed [SW-1:0]         sum;
	logic signed [SW-1:0]         sat;
	logic [COEF_BITS-1:0]         result;
	logic                         out_valid_q;
	logic [COEF_BITS-1:0]         qf_value_q;
	logic [m4acdc_pkg::DEN_BITS-1:0] dc_scale_q;

	always_comb begin
		coef_ext = {{(SW - COEF_BITS){coef_c[NB][COEF_BITS-1]}}, coef_c[NB]};
		term     = st_c[NB].neg ? (SW'(0) - SW'(st_c[NB].quot)) : SW'(st_c[NB].quot);
		sum      = coef_ext + term;
		if (sum > SAT_HI)
			sat = SAT_HI;
		else if (sum < SAT_LO)
			sat = SAT_LO;
		else
			sat = sum;
		case (st_c[NB].mode)
			m4acdc_pkg::MODE_DC: result = sat[COEF_BITS-1:0];
			m4acdc_pkg::MODE_AC: result = sat[COEF_BITS-1:0];
			default:             result = coef_c[NB];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= v_c[NB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qf_value_q <= result;
			dc_scale_q <= st_c[NB].scaler;
		end
	end

	assign out_valid = out_valid_q;
	assign qf_value  = qf_value_q;
	assign dc_scale  = dc_scale_q;

	`M4ACDC_ASSERT_IMPL(a_scaler_range, clk, arst_n, out_valid,
		(dc_scale >= 6'd8) && (dc_scale <= 6'd46))
	`M4ACDC_ASSERT_IMPL(a_rem_below_den, clk, arst_n, v_c[NB],
		st_c[NB].rem < st_c[NB].den)
	`M4ACDC_ASSERT_IMPL(a_dc_quot_bound, clk, arst_n,
		v_c[NB] && (st_c[NB].mode == m4acdc_pkg::MODE_DC), st_c[NB].quot <= NB'(4099))
	`M4ACDC_ASSERT_NEXT(a_front_scaler, clk, arst_n, in_valid && in_ready,
		front_s1.scaler >= 6'd8)

endmodule
`default_nettype wire

>>> tb/mpeg4_inverse_acdc_prediction_top_tb.sv
// Testbench for mpeg4_inverse_acdc_prediction_top (imports m4acdc_pkg): directed table, then
// random coefficients; typed rows checked against the table, others against a DC/AC model.
`default_nettype none
module mpeg4_inverse_acdc_prediction_top_tb;
	import m4acdc_pkg::*;

	localparam int COEF_W      = 12;
	localparam int PHASES      = 13;
	localparam int PHASE_ITEMS = 150;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_WAIT  = 30;

	typedef struct packed {
		logic [5:0]                 idx;
		logic signed [COEF_W-1:0]   coef;
		logic signed [PRED_BITS-1:0] pred;
		logic                       chroma;
		logic                       dir;
		logic [QP_BITS-1:0]         qpp;
	} coef_item_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] qf;
		logic [DEN_BITS-1:0]      scaler;
	} acdc_result_t;

	typedef struct {
		int           quant;
		bit           ac_en;
		coef_item_t   item;
		bit           typed;
		acdc_result_t res;
	} directed_row_t;

	logic                        clk;
	logic                        arst_n;
	logic                        cfg_we;
	logic                        cfg_index;
	logic [CFG_DATA_BITS-1:0]    cfg_data;
	logic                        in_valid;
	logic                        in_ready;
	logic [5:0]                  coef_index;
	logic signed [COEF_W-1:0]    coef_value;
	logic signed [PRED_BITS-1:0] pred_value;
	logic                        block_is_chroma;
	logic                        direction;
	logic [QP_BITS-1:0]          qp_pred;
	logic                        out_valid;
	logic                        out_ready;
	logic signed [COEF_W-1:0]    qf_value;
	logic [DEN_BITS-1:0]         dc_scale;

	logic [QP_BITS-1:0] reg_quant;
	logic               reg_ac_en;
	bit                 row_typed;
	acdc_result_t       row_expect;
	bit                 quiet;
	int                 mismatch_count;
	int                 stall_cycles;
	acdc_result_t       expected_coefs[$];
	directed_row_t      directed_rows[$];
	coef_item_t         seen_item;
	acdc_result_t       want;
	int                 phase_quant [PHASES] = '{4, 8, 9, 24, 25, 31, 0, 1, 16, 2, 5, -1, -1};

	mpeg4_inverse_acdc_prediction_top #(
		.COEF_BITS(COEF_W)
	) i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.coef_index     (coef_index),
		.coef_value     (coef_value),
		.pred_value     (pred_value),
		.block_is_chroma(block_is_chroma),
		.direction      (direction),
		.qp_pred        (qp_pred),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.qf_value       (qf_value),
		.dc_scale       (dc_scale)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic longint div_round_away(longint num, longint den);
		if (num > 0)
			return (num + den / 2) / den;
		return (num - den / 2) / den;
	endfunction

	function automatic longint clamp_coef(longint v);
		if (v < -2048)
			return -2048;
		if (v > 2047)
			return 2047;
		return v;
	endfunction

	function automatic acdc_result_t predict_coef(coef_item_t it);
		int           q;
		int           scaler;
		longint       acc;
		longint       pred;
		bit           in_row;
		bit           in_col;
		acdc_result_t res;
		q = (reg_quant == 0) ? 1 : int'(reg_quant);
		if (q < 5)
			scaler = 8;
		else if (!it.chroma)
			scaler = (q < 9) ? 2 * q : (q < 25) ? q + 8 : 2 * q - 16;
		else
			scaler = (q < 25) ? (q + 13) / 2 : q - 6;
		acc  = longint'($signed(it.coef));
		pred = longint'($signed(it.pred));
		in_row = (it.dir == 1'b0) && (it.idx < 6'd8);
		in_col = (it.dir == 1'b1) && (it.idx[2:0] == 3'd0);
		if (it.idx == 6'd0)
			acc = clamp_coef(acc + div_round_away(pred, scaler));
		else if (reg_ac_en && (in_row || in_col) && pred != 0)
			acc = clamp_coef(acc + div_round_away(pred * longint'(it.qpp), q));
		res.qf     = acc[COEF_W-1:0];
		res.scaler = scaler[DEN_BITS-1:0];
		return res;
	endfunction

	function automatic void add_row(int quant, bit ac_en, int idx, int coef, int pred,
		bit chroma, bit dir, int qpp, bit typed, int qf, int scaler);
		directed_row_t r;
		r.quant       = quant;
		r.ac_en       = ac_en;
		r.item.idx    = idx[5:0];
		r.item.coef   = coef[COEF_W-1:0];
		r.item.pred   = pred[PRED_BITS-1:0];
		r.item.chroma = chroma;
		r.item.dir    = dir;
		r.item.qpp    = qpp[QP_BITS-1:0];
		r.typed       = typed;
		r.res.qf      = qf[COEF_W-1:0];
		r.res.scaler  = scaler[DEN_BITS-1:0];
		directed_rows.push_back(r);
	endfunction

	function automatic coef_item_t random_coef();
		coef_item_t it;
		int         sel;
		sel = $urandom_range(0, 9);
		if (sel < 3)
			it.idx = 6'd0;
		else if (sel < 6)
			it.idx = 6'($urandom_range(1, 7));
		else if (sel < 9)
			it.idx = 6'($urandom_range(1, 7) * 8);
		else
			it.idx = 6'($urandom_range(0, 63));
		sel = $urandom_range(0, 7);
		case (sel)
			0: it.coef = 12'sd2047;
			1: it.coef = -12'sd2048;
			2, 3: it.coef = 12'($urandom_range(0, 64) - 32);
			default: it.coef = 12'($urandom);
		endcase
		sel = $urandom_range(0, 7);
		case (sel)
			0: it.pred = '0;
			1: it.pred = 16'sd32767;
			2: it.pred = -16'sd32768;
			3, 4: it.pred = 16'($urandom_range(0, 200) - 100);
			default: it.pred = 16'($urandom);
		endcase
		it.chroma = 1'($urandom_range(0, 1));
		it.dir    = 1'($urandom_range(0, 1));
		it.qpp    = 5'($urandom_range(0, 31));
		return it;
	endfunction

	task automatic apply_config(int quant, bit ac_en);
		in_valid <= 1'b0;
		while (expected_coefs.size() != 0)
			@(posedge clk);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_QUANT;
		cfg_data  <= quant[CFG_DATA_BITS-1:0];
		@(negedge clk);
		cfg_index <= CFG_AC_PRED;
		cfg_data  <= {{(CFG_DATA_BITS-1){1'b0}}, ac_en};
		@(negedge clk);
		cfg_we    <= 1'b0;
		reg_quant = quant[QP_BITS-1:0];
		reg_ac_en = ac_en;
	endtask

	task automatic send_coef(coef_item_t it, bit typed, acdc_result_t res);
		in_valid        <= 1'b1;
		coef_index      <= it.idx;
		coef_value      <= it.coef;
		pred_value      <= it.pred;
		block_is_chroma <= it.chroma;
		direction       <= it.dir;
		qp_pred         <= it.qpp;
		row_typed  = typed;
		row_expect = res;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic idle_gap(int n);
		in_valid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	// receiver: random ready bursts, long open stretches, none when quiet
	initial begin
		int hold;
		bit level;
		out_ready = 1'b0;
		hold      = 0;
		level     = 1'b0;
		forever begin
			@(negedge clk);
			if (quiet) begin
				out_ready <= 1'b1;
			end else begin
				if (hold == 0) begin
					level = ($urandom_range(0, 2) != 0);
					if (!level)
						hold = $urandom_range(1, 16);
					else if ($urandom_range(0, 3) == 0)
						hold = $urandom_range(50, 200);
					else
						hold = $urandom_range(1, 16);
				end
				hold--;
				out_ready <= level;
			end
		end
	end

	// transaction monitor, scoreboard and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				seen_item = '{coef_index, coef_value, pred_value, block_is_chroma,
					direction, qp_pred};
				expected_coefs.push_back(row_typed ? row_expect : predict_coef(seen_item));
			end
			if (out_valid && out_ready) begin
				if (expected_coefs.size() == 0) begin
					$error("unexpected result: qf_value %0d dc_scale %0d", qf_value, dc_scale);
					mismatch_count++;
				end else begin
					want = expected_coefs.pop_front();
					if (qf_value !== want.qf) begin
						$error("qf_value: expected %0d, got %0d", want.qf, qf_value);
						mismatch_count++;
					end
					if (dc_scale !== want.scaler) begin
						$error("dc_scale: expected %0d, got %0d", want.scaler, dc_scale);
						mismatch_count++;
					end
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin
		int           cur_quant;
		bit           cur_ac;
		int           q;
		int           gap_pct;
		directed_row_t r;
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = CFG_QUANT;
		cfg_data        = '0;
		in_valid        = 1'b0;
		coef_index      = '0;
		coef_value      = '0;
		pred_value      = '0;
		block_is_chroma = 1'b0;
		direction       = 1'b0;
		qp_pred         = '0;
		reg_quant       = 5'd1;
		reg_ac_en       = 1'b0;
		row_typed       = 1'b0;
		row_expect      = '0;
		quiet           = 1'b0;
		mismatch_count  = 0;
		stall_cycles    = 0;
		cur_quant       = 1;
		cur_ac          = 1'b0;

		// reset values
		add_row(1, 0, 0, 0, 0, 0, 0, 1, 1, 0, 8);
		add_row(1, 0, 0, 2047, 32767, 0, 0, 1, 1, 2047, 8);
		add_row(1, 0, 0, -2048, -32768, 1, 1, 31, 1, -2048, 8);
		add_row(1, 0, 63, -2048, 32767, 1, 0, 31, 1, -2048, 8);
		add_row(1, 0, 1, 2047, -32768, 0, 0, 31, 1, 2047, 8);
		// prediction at quant 31, saturating both ways
		add_row(31, 1, 7, 2047, 32767, 0, 0, 31, 1, 2047, 46);
		add_row(31, 1, 56, -2048, -32768, 1, 1, 31, 1, -2048, 25);
		add_row(31, 1, 8, 100, 1000, 0, 0, 7, 0, 0, 0);
		add_row(31, 1, 1, -5, 1000, 1, 1, 7, 0, 0, 0);
		add_row(31, 1, 16, 33, 0, 0, 1, 20, 0, 0, 0);
		add_row(31, 1, 3, -77, 12345, 0, 0, 0, 0, 0, 0);
		add_row(31, 1, 9, 500, -999, 1, 1, 31, 0, 0, 0);
		add_row(31, 1, 0, 12, -700, 1, 1, 3, 0, 0, 0);
		// quant of zero acts as one
		add_row(0, 1, 0, 5, 100, 0, 0, 1, 1, 18, 8);
		add_row(0, 1, 2, 0, -3, 1, 0, 5, 0, 0, 0);
		// rounding of halves away from zero
		add_row(2, 1, 1, 0, 3, 0, 0, 1, 0, 0, 0);
		add_row(2, 1, 1, 0, -3, 0, 0, 1, 0, 0, 0);
		// scaler breakpoints
		add_row(5, 0, 0, 0, 0, 0, 0, 1, 1, 0, 10);
		add_row(5, 0, 0, 0, 0, 1, 0, 1, 1, 0, 9);
		add_row(24, 0, 0, 0, 0, 0, 0, 1, 1, 0, 32);
		add_row(24, 0, 0, 0, 0, 1, 0, 1, 1, 0, 18);
		add_row(25, 0, 0, 0, 0, 0, 0, 1, 1, 0, 34);
		add_row(25, 0, 0, 0, 0, 1, 0, 1, 1, 0, 19);
		add_row(9, 1, 0, 0, 0, 0, 0, 1, 1, 0, 17);
		add_row(8, 1, 0, 0, 0, 1, 0, 1, 1, 0, 10);

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			r = directed_rows[i];
			if (r.quant != cur_quant || r.ac_en != cur_ac) begin
				apply_config(r.quant, r.ac_en);
				cur_quant = r.quant;
				cur_ac    = r.ac_en;
			end
			send_coef(r.item, r.typed, r.res);
		end

		for (int p = 0; p < PHASES; p++) begin
			q = (phase_quant[p] < 0) ? $urandom_range(1, 31) : phase_quant[p];
			apply_config(q, (p % 3) != 2);
			quiet   = (p >= PHASES - 2);
			gap_pct = quiet ? 0 : $urandom_range(0, 3) * 12;
			repeat (PHASE_ITEMS) begin
				if (!quiet && $urandom_range(0, 99) < gap_pct)
					idle_gap($urandom_range(1, 16));
				send_coef(random_coef(), 1'b0, '0);
			end
		end

		in_valid <= 1'b0;
		while (expected_coefs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
`default_nettype wire

>>> sim.f
+incdir+design
design/m4acdc_pkg.sv
design/m4acdc_div_cell.sv
design/mpeg4_inverse_acdc_prediction_top.sv
tb/mpeg4_inverse_acdc_prediction_top_tb.sv
